// ===== src/npi_pkg.sv =====
// Shared types and constants for the nearest palette index block.
// Used by npi_dist, nearest_palette_index and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package npi_pkg;

	// Parameter defaults
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int CHANNEL_BITS_DEF    = 8;

	// Field widths fixed by the interface
	localparam int PSIZE_W = 9;
	localparam int DIST_W  = 10;

	// Output distance saturates here
	localparam logic [DIST_W-1:0] DIST_MAX = 10'd1023;

	// Luminance weights in thousandths and their divisor
	localparam logic [9:0] W_RED   = 10'd299;
	localparam logic [9:0] W_GREEN = 10'd587;
	localparam logic [9:0] W_BLUE  = 10'd114;
	localparam int         DIVISOR = 1000;

	// Input item kinds carried on tuser
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic CFG_PSIZE = 1'b0;
	localparam logic CFG_GREY  = 1'b1;

	// Control that travels with each palette read through the pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

`default_nettype wire

// ===== src/npi_palette_mem.sv =====
// Palette storage: single write port, single read port, registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module npi_palette_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/npi_dist.sv =====
// Three-stage distance pipeline: channel differences, weighted sum, divide by 1000 in luminance mode.
// Depends on npi_pkg for weights, divisor and the pipeline tag type.
`timescale 1ns / 1ps
`default_nettype none

module npi_dist import npi_pkg::*; #(
	parameter int CB    = CHANNEL_BITS_DEF,
	parameter int IDX_W = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            grey,
	input  wire tag_t            tag_in,
	input  wire logic [IDX_W-1:0] idx_in,
	input  wire logic [CB-1:0]   pix_r,
	input  wire logic [CB-1:0]   pix_g,
	input  wire logic [CB-1:0]   pix_b,
	input  wire logic [3*CB-1:0] entry,
	output tag_t                 tag_out,
	output logic [IDX_W-1:0]     idx_out,
	output logic [CB+1:0]        dist_out
);

	localparam int DW = CB + 2;
	localparam int WS = CB + 10;
	localparam int SH = WS + 10;
	localparam int PW = 2 * WS + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [WS:0] RECIP = RECIP_FULL[WS:0];

	logic [CB-1:0]    ent_r, ent_g, ent_b;
	logic [CB-1:0]    dr_s2, dg_s2, db_s2;
	logic [WS-1:0]    sum_s3;
	logic [PW-1:0]    prod;
	logic [PW-SH-1:0] quot;
	tag_t             tag_s2, tag_s3, tag_s4;
	logic [IDX_W-1:0] idx_s2, idx_s3, idx_s4;
	logic [DW-1:0]    dist_s4;

	assign ent_r = entry[CB-1:0];
	assign ent_g = entry[2*CB-1:CB];
	assign ent_b = entry[3*CB-1:2*CB];

	// Carry control through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Absolute channel differences
	always_ff @(posedge clk) begin
		dr_s2  <= (pix_r > ent_r) ? pix_r - ent_r : ent_r - pix_r;
		dg_s2  <= (pix_g > ent_g) ? pix_g - ent_g : ent_g - pix_g;
		db_s2  <= (pix_b > ent_b) ? pix_b - ent_b : ent_b - pix_b;
		idx_s2 <= idx_in;
	end

	// Plain or luminance weighted sum
	always_ff @(posedge clk) begin
		if (grey) begin
			sum_s3 <= WS'(dr_s2) * WS'(W_RED) + WS'(dg_s2) * WS'(W_GREEN)
				+ WS'(db_s2) * WS'(W_BLUE);
		end else begin
			sum_s3 <= WS'(dr_s2) + WS'(dg_s2) + WS'(db_s2);
		end
		idx_s3 <= idx_s2;
	end

	// Exact floor division by 1000 through a rounded-up reciprocal
	assign prod = PW'(sum_s3) * PW'(RECIP);
	assign quot = prod[PW-1:SH];

	always_ff @(posedge clk) begin
		dist_s4 <= grey ? DW'(quot) : DW'(sum_s3);
		idx_s4  <= idx_s3;
	end

	assign tag_out  = tag_s4;
	assign idx_out  = idx_s4;
	assign dist_out = dist_s4;

endmodule

`default_nettype wire

// ===== src/nearest_palette_index.sv =====
// Nearest palette entry search: L1 or luminance weighted distance, lowest index on ties.
// The search makes one palette read per cycle over n entries, n = effective
// palette size; the next item is taken the cycle after the result is loaded, so a
// new pixel waits until the last one is through. A write leaves the block idle.
// Reset clears control and sets size 1, L1 mode; palette contents undefined until written.
// Depends on npi_pkg, npi_palette_mem and npi_dist.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_index import npi_pkg::*; #(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
	parameter int CHANNEL_BITS    = CHANNEL_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  wire logic [0:0]  s_tuser,   // action[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // palette_index[7:0], min_distance[17:8], zero[23:18]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data
);

	localparam int CB    = CHANNEL_BITS;
	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam int CMP_W = (IDX_W + 1 > PSIZE_W) ? IDX_W + 1 : PSIZE_W;
	localparam int DW    = CB + 2;
	localparam int XW    = (DW > DIST_W) ? DW : DIST_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [PSIZE_W-1:0] psize_q;
	logic               grey_q;
	logic [IDX_W-1:0]   addr_q, lim_q, lim_nx;
	logic [CB-1:0]      pix_r_q, pix_g_q, pix_b_q;
	tag_t               tag_s1, dtag;
	logic [IDX_W-1:0]   idx_s1, didx;
	logic [DW-1:0]      ddist;
	logic [IDX_W-1:0]   best_idx_q;
	logic [DW-1:0]      best_d_q;
	logic               m_tvalid_q;
	logic [7:0]         out_idx_q;
	logic [DIST_W-1:0]  out_d_q;
	logic [3*CB-1:0]    rd_entry;
	logic               in_xfer, wr_en, issue, load_out;
	logic [CMP_W-1:0]   psz_ext, wr_ext;
	logic [XW-1:0]      best_ext;

	// Input side
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign wr_ext   = CMP_W'(s_tdata[7:0]);
	assign wr_en    = in_xfer && (s_tuser[0] == ACT_WRITE)
		&& (wr_ext < CMP_W'(PALETTE_ENTRIES));

	// Clamp the searched range to 1..PALETTE_ENTRIES
	assign psz_ext = CMP_W'(psize_q);
	always_comb begin
		priority if (psz_ext == '0) begin
			lim_nx = '0;
		end else if (psz_ext > CMP_W'(PALETTE_ENTRIES)) begin
			lim_nx = IDX_W'(PALETTE_ENTRIES - 1);
		end else begin
			lim_nx = IDX_W'(psz_ext - CMP_W'(1));
		end
	end

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= PSIZE_W'(1);
			grey_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PSIZE: psize_q <= cfg_data;
				CFG_GREY:  grey_q  <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// Palette memory
	npi_palette_mem #(
		.DEPTH(PALETTE_ENTRIES),
		.WIDTH(3 * CB)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(wr_ext)),
		.wdata ({CB'(s_tdata[31:24]), CB'(s_tdata[23:16]), CB'(s_tdata[15:8])}),
		.raddr (addr_q),
		.rdata (rd_entry)
	);

	// Align read control with the registered memory data
	assign issue = (state_q == ST_RUN);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= issue;
			tag_s1.last  <= issue && (addr_q == lim_q);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	// Distance pipeline
	npi_dist #(
		.CB    (CB),
		.IDX_W (IDX_W)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.grey     (grey_q),
		.tag_in   (tag_s1),
		.idx_in   (idx_s1),
		.pix_r    (pix_r_q),
		.pix_g    (pix_g_q),
		.pix_b    (pix_b_q),
		.entry    (rd_entry),
		.tag_out  (dtag),
		.idx_out  (didx),
		.dist_out (ddist)
	);

	// Hold the pixel for the whole search
	always_ff @(posedge clk) begin
		if (in_xfer && (s_tuser[0] == ACT_PIXEL)) begin
			pix_r_q <= CB'(s_tdata[15:8]);
			pix_g_q <= CB'(s_tdata[23:16]);
			pix_b_q <= CB'(s_tdata[31:24]);
			lim_q   <= lim_nx;
		end
	end

	// Sequencer: issue reads, drain pipeline, hand over result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (in_xfer && (s_tuser[0] == ACT_PIXEL)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == lim_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (dtag.valid && dtag.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Keep the smallest distance; entry zero always opens the search
	always_ff @(posedge clk) begin
		if (dtag.valid && ((didx == '0) || (ddist < best_d_q))) begin
			best_idx_q <= didx;
			best_d_q   <= ddist;
		end
	end

	// Output register
	assign load_out = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign best_ext = XW'(best_d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q <= 8'(CMP_W'(best_idx_q));
			out_d_q   <= (best_ext > XW'(DIST_MAX)) ? DIST_MAX : DIST_W'(best_ext);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_d_q, out_idx_q};

	// Reads never run past the clamped palette size
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (addr_q <= lim_q))
		else $error("palette read beyond searched range");

	// A result appears only after a finished search
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised without finished search");

	// Distances reach the compare stage only while a search is under way
	a_no_stray_dist: assert property (@(posedge clk) disable iff (!arst_n)
		dtag.valid |-> ((state_q == ST_RUN) || (state_q == ST_DRAIN)))
		else $error("distance arrived outside a search");

endmodule

`default_nettype wire

// ===== tb/tb_nearest_palette_index.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_palette_index: a directed table, then palette phases with
// random pixels and entry rewrites, checked against table values or a nearest-entry predictor.
// Depends on npi_pkg and the nearest_palette_index RTL.

module tb_nearest_palette_index import npi_pkg::*;;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0] idx;
		logic [9:0] min_d;
	} match_t;

	// One row of the directed table: a register write or a stream transfer
	typedef struct packed {
		bit         is_cfg;
		logic       sel;
		logic [8:0] val;
		logic       act;
		logic [7:0] idx;
		rgb_t       pix;
		bit         typed;
		match_t     want;
	} step_t;

	typedef struct {
		logic [8:0] size;
		logic       grey;
		int         count;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_data = '0;

	// Predictor state: palette copy and register copies
	rgb_t       pal_copy [256];
	logic [8:0] size_reg = 9'd1;
	logic       grey_reg = 1'b0;
	match_t     pending_matches [$];
	bit         calm = 1'b0;
	int         mismatches = 0;
	int         n_writes = 0;
	int         n_pixels = 0;
	int         n_checked = 0;

	nearest_palette_index uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Stall the result side about 37 percent of the time, never during the calm stretch
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 37);
	end

	// Search entries 0..n-1 for the smallest distance, lowest index on ties
	function automatic match_t nearest_entry(rgb_t px);
		int n, d, best, bestd, dr, dg, db;
		match_t m;
		n = (size_reg == 0) ? 1 : ((size_reg > 256) ? 256 : int'(size_reg));
		best = 0;
		bestd = 0;
		for (int i = 0; i < n; i++) begin
			dr = (px.red > pal_copy[i].red) ? px.red - pal_copy[i].red
				: pal_copy[i].red - px.red;
			dg = (px.green > pal_copy[i].green) ? px.green - pal_copy[i].green
				: pal_copy[i].green - px.green;
			db = (px.blue > pal_copy[i].blue) ? px.blue - pal_copy[i].blue
				: pal_copy[i].blue - px.blue;
			d = grey_reg ? (299 * dr + 587 * dg + 114 * db) / 1000 : dr + dg + db;
			if (i == 0 || d < bestd) begin
				best = i;
				bestd = d;
			end
		end
		if (bestd > 1023) bestd = 1023;
		m.idx = best[7:0];
		m.min_d = bestd[9:0];
		return m;
	endfunction

	// Move a channel by up to four steps either way, held inside 0..255
	function automatic logic [7:0] nudge(logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 8)) - 4;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic step_t put_entry(logic [7:0] slot, logic [7:0] r, g, b);
		step_t s;
		s = '0;
		s.act = ACT_WRITE;
		s.idx = slot;
		s.pix = {r, g, b};
		return s;
	endfunction

	function automatic step_t pixel(logic [7:0] r, g, b);
		step_t s;
		s = '0;
		s.act = ACT_PIXEL;
		s.pix = {r, g, b};
		return s;
	endfunction

	function automatic step_t pixel_is(logic [7:0] r, g, b, logic [7:0] ei, logic [9:0] ed);
		step_t s;
		s = pixel(r, g, b);
		s.typed = 1'b1;
		s.want = {ei, ed};
		return s;
	endfunction

	function automatic step_t set_reg(logic sel, logic [8:0] val);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.sel = sel;
		s.val = val;
		return s;
	endfunction

	// Present one item with a random lead-in gap, hold until the transfer, then update the palette copy or predict
	task automatic send_item(logic act, logic [7:0] idx, rgb_t px, bit typed, match_t want);
		match_t exp_m;
		while (!calm && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {px.blue, px.green, px.red, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ACT_WRITE) begin
			pal_copy[idx] = px;
			n_writes++;
		end else begin
			exp_m = typed ? want : nearest_entry(px);
			pending_matches = {pending_matches, exp_m};
			n_pixels++;
		end
	endtask

	// Write a register once the block has drained and settled
	task automatic write_reg(logic sel, logic [8:0] val);
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (sel == CFG_PSIZE) size_reg = val;
		else grey_reg = val[0];
	endtask

	task automatic report_mismatch(string what, match_t want);
		if (mismatches < 10)
			$display("%t %s: expected index %0d distance %0d, got index %0d distance %0d",
				$realtime, what, want.idx, want.min_d, m_tdata[7:0], m_tdata[17:8]);
		mismatches++;
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (pending_matches.size() == 0) begin
				report_mismatch("result with nothing pending", '0);
			end else begin
				if (m_tdata[7:0] !== pending_matches[0].idx)
					report_mismatch("palette_index differs", pending_matches[0]);
				else if (m_tdata[17:8] !== pending_matches[0].min_d)
					report_mismatch("min_distance differs", pending_matches[0]);
				void'(pending_matches.pop_front());
			end
		end
	end

	initial begin : stimulus
		step_t  plan [$];
		phase_t phases [$];
		rgb_t   px;
		logic [7:0] slot;
		int     n_eff, pick;

		// Entries 0..3 only; the size stays within them until the full fill
		plan = '{
			put_entry(8'd0, 8'd0, 8'd0, 8'd0),
			pixel_is(8'd0, 8'd0, 8'd0, 8'd0, 10'd0),
			pixel_is(8'd255, 8'd255, 8'd255, 8'd0, 10'd765),
			put_entry(8'd1, 8'd255, 8'd255, 8'd255),
			pixel_is(8'd255, 8'd255, 8'd255, 8'd0, 10'd765),
			set_reg(CFG_PSIZE, 9'd2),
			pixel_is(8'd255, 8'd255, 8'd255, 8'd1, 10'd0),
			pixel(8'd128, 8'd128, 8'd128),
			put_entry(8'd2, 8'd0, 8'd0, 8'd0),
			put_entry(8'd3, 8'd255, 8'd0, 8'd0),
			set_reg(CFG_PSIZE, 9'd4),
			pixel_is(8'd0, 8'd0, 8'd0, 8'd0, 10'd0),
			pixel_is(8'd250, 8'd0, 8'd0, 8'd3, 10'd5),
			set_reg(CFG_PSIZE, 9'd0),
			pixel_is(8'd255, 8'd0, 8'd0, 8'd0, 10'd255),
			set_reg(CFG_GREY, 9'd1),
			pixel_is(8'd255, 8'd255, 8'd255, 8'd0, 10'd255),
			pixel_is(8'd0, 8'd0, 8'd100, 8'd0, 10'd11),
			set_reg(CFG_PSIZE, 9'd4),
			pixel_is(8'd250, 8'd10, 8'd0, 8'd3, 10'd7),
			pixel_is(8'd0, 8'd0, 8'd1, 8'd0, 10'd0),
			pixel(8'd200, 8'd100, 8'd50),
			set_reg(CFG_GREY, 9'd0)
		};

		// Mostly small palettes; the largest sizes get only a few pixels
		phases = '{
			'{9'd2,   1'b0, 90},
			'{9'd0,   1'b1, 60},
			'{9'd5,   1'b0, 90},
			'{9'd256, 1'b1, 12},
			'{9'd3,   1'b1, 90},
			'{9'd16,  1'b0, 90},
			'{9'd511, 1'b0, 12},
			'{9'd1,   1'b0, 60},
			'{9'd8,   1'b1, 90},
			'{9'd300, 1'b1, 10},
			'{9'd32,  1'b0, 60},
			'{9'd4,   1'b0, 110}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (plan[k]) begin
			if (plan[k].is_cfg)
				write_reg(plan[k].sel, plan[k].val);
			else
				send_item(plan[k].act, plan[k].idx, plan[k].pix, plan[k].typed, plan[k].want);
		end

		// Load every entry; some repeat their neighbor so that ties occur
		for (int e = 0; e < 256; e++) begin
			if (e > 0 && $urandom_range(0, 7) == 0)
				px = pal_copy[e - 1];
			else
				px = 24'($urandom);
			send_item(ACT_WRITE, 8'(e), px, 1'b0, '0);
		end

		// Random phases, each under one register setting
		foreach (phases[p]) begin
			write_reg(CFG_PSIZE, phases[p].size);
			write_reg(CFG_GREY, {8'd0, phases[p].grey});
			calm <= (p == 4 || p == 5);
			n_eff = (phases[p].size == 0) ? 1
				: ((phases[p].size > 256) ? 256 : int'(phases[p].size));
			repeat (phases[p].count) begin
				pick = $urandom_range(0, n_eff - 1);
				if ($urandom_range(0, 3) == 0) begin
					// Rewrite an entry, often inside the searched range
					slot = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'(pick);
					case ($urandom_range(0, 2))
						0: px = 24'($urandom);
						1: px = pal_copy[8'($urandom)];
						default: px = pal_copy[$urandom_range(0, n_eff - 1)];
					endcase
					send_item(ACT_WRITE, slot, px, 1'b0, '0);
				end else begin
					case ($urandom_range(0, 3))
						0: px = 24'($urandom);
						1: px = pal_copy[pick];
						2: px = {nudge(pal_copy[pick].red), nudge(pal_copy[pick].green),
							nudge(pal_copy[pick].blue)};
						default: begin
							px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
							px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
							px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						end
					endcase
					send_item(ACT_PIXEL, 8'($urandom), px, 1'b0, '0);
				end
			end
		end

		// Drain and let the block settle
		s_tvalid <= 1'b0;
		calm <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("%0d palette writes and %0d pixels sent, %0d results compared",
			n_writes, n_pixels, n_checked);
		$display("palette sizes 0 to 511 in L1 and luminance modes, %0d mismatches", mismatches);
		if (mismatches == 0 && pending_matches.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hang
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
